// File: rtl/core/slcd_pkg.sv
package slcd_pkg;

    // Magnitude of any in-range value fits in 14 bits (9999 max).
    localparam int MAG_W = 14;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic signed [15:0] VALUE_MIN = -16'sd999;
    localparam logic signed [15:0] VALUE_MAX = 16'sd9999;

    // Fixed error pattern for out-of-range values.
    localparam logic [7:0] ERR_ROW0_LOW  = 8'h03;
    localparam logic [3:0] ERR_ROW0_HIGH = 4'h0;
    localparam logic [7:0] ERR_ROW1_LOW  = 8'h20;
    localparam logic [7:0] ERR_ROW1_HIGH = 8'hC0;
    localparam logic [7:0] ERR_ROW2_LOW  = 8'hDB;
    localparam logic [3:0] ERR_ROW2_HIGH = 4'h6;

    typedef logic [4:0] sym_t;
    localparam sym_t SYM_MINUS = 5'd16;
    localparam sym_t SYM_BLANK = 5'd17;

    // Three 3-bit row patterns; common r sits in bits 3r+2..3r.
    typedef logic [8:0] glyph_t;

    // Classified transaction handed from the front to the back.
    typedef struct packed {
        logic             out_of_range;
        logic             negative;
        logic [MAG_W-1:0] mag;
        logic [3:0]       q1000;
        logic [6:0]       q100;
        logic [9:0]       q10;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic glyph_t glyph(input sym_t s);
        glyph_t g;
        case (s)
            5'd0:    g = {3'h5, 3'h6, 3'h3};
            5'd1:    g = {3'h4, 3'h4, 3'h0};
            5'd2:    g = {3'h7, 3'h2, 3'h2};
            5'd3:    g = {3'h6, 3'h6, 3'h2};
            5'd4:    g = {3'h6, 3'h4, 3'h1};
            5'd5:    g = {3'h2, 3'h6, 3'h3};
            5'd6:    g = {3'h3, 3'h6, 3'h3};
            5'd7:    g = {3'h4, 3'h4, 3'h2};
            5'd8:    g = {3'h7, 3'h6, 3'h3};
            5'd9:    g = {3'h6, 3'h6, 3'h3};
            5'd10:   g = {3'h7, 3'h4, 3'h3};
            5'd11:   g = {3'h3, 3'h6, 3'h1};
            5'd12:   g = {3'h1, 3'h2, 3'h3};
            5'd13:   g = {3'h7, 3'h6, 3'h0};
            5'd14:   g = {3'h3, 3'h2, 3'h3};
            5'd15:   g = {3'h3, 3'h0, 3'h3};
            5'd16:   g = {3'h2, 3'h0, 3'h0};
            default: g = {3'h0, 3'h0, 3'h0};
        endcase
        return g;
    endfunction

endpackage

// File: rtl/core/slcd_front.sv
module slcd_front (
    input  logic signed [15:0] value,
    output slcd_pkg::item_t    item
);
    import slcd_pkg::*;

    logic [15:0]       mag_full;
    logic [MAG_W-1:0]  mag;
    logic [28:0]       prod1000;
    logic [26:0]       prod100;
    logic [29:0]       prod10;

    always_comb
    begin
        mag_full = value[15] ? (16'd0 - value) : value;
        mag      = mag_full[MAG_W-1:0];
        // Reciprocal multiplies, exact for every magnitude below 16384.
        prod1000 = 29'(mag) * 29'd16778;
        prod100  = 27'(mag) * 27'd5243;
        prod10   = 30'(mag) * 30'd52429;

        item.out_of_range = (value < VALUE_MIN) || (value > VALUE_MAX);
        item.negative     = value[15];
        item.mag          = mag;
        item.q1000        = prod1000[27:24];
        item.q100         = prod100[25:19];
        item.q10          = prod10[28:19];
    end

endmodule

// File: rtl/core/slcd_queue.sv
module slcd_queue #(
    parameter int DEPTH = slcd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  slcd_pkg::item_t         push_item,
    input  logic                    pop,
    output slcd_pkg::item_t         head_item,
    output slcd_pkg::queue_status_t status
);
    import slcd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    item_t          store_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item    = store_reg[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);

endmodule

// File: rtl/core/slcd_back.sv
module slcd_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  slcd_pkg::item_t         head_item,
    input  slcd_pkg::queue_status_t status,
    output logic                    pop,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic [7:0]              row0_low,
    output logic [3:0]              row0_high,
    output logic [7:0]              row1_low,
    output logic [7:0]              row1_high,
    output logic [7:0]              row2_low,
    output logic [3:0]              row2_high,
    output logic                    out_of_range
);
    import slcd_pkg::*;

    logic [3:0]  d3, d2, d1, d0;
    logic [6:0]  t2;
    logic [9:0]  t1;
    logic [13:0] t0;
    sym_t        sym [4];
    glyph_t      g [4];
    logic [11:0] com [3];

    logic        valid_reg, valid_next;
    logic [7:0]  row0_low_reg, row1_low_reg, row1_high_reg, row2_low_reg;
    logic [3:0]  row0_high_reg, row2_high_reg;
    logic        oor_reg;

    // Digits come from the independent quotients: digit = q - 10 * q_next_up.
    always_comb
    begin
        d3 = head_item.q1000;
        t2 = head_item.q100 - ({3'b0, head_item.q1000} << 3)
                            - ({3'b0, head_item.q1000} << 1);
        t1 = head_item.q10 - ({3'b0, head_item.q100} << 3)
                           - ({3'b0, head_item.q100} << 1);
        t0 = head_item.mag - ({4'b0, head_item.q10} << 3)
                           - ({4'b0, head_item.q10} << 1);
        d2 = t2[3:0];
        d1 = t1[3:0];
        d0 = t0[3:0];

        if (!head_item.negative)
        begin
            sym[0] = (head_item.q1000 == '0) ? SYM_BLANK : {1'b0, d3};
            sym[1] = (head_item.q100 == '0) ? SYM_BLANK : {1'b0, d2};
            sym[2] = (head_item.q10 == '0) ? SYM_BLANK : {1'b0, d1};
        end
        else if (head_item.q10 == '0)
        begin
            sym[0] = SYM_BLANK;
            sym[1] = SYM_BLANK;
            sym[2] = SYM_MINUS;
        end
        else if (head_item.q100 == '0)
        begin
            sym[0] = SYM_BLANK;
            sym[1] = SYM_MINUS;
            sym[2] = {1'b0, d1};
        end
        else
        begin
            sym[0] = SYM_MINUS;
            sym[1] = {1'b0, d2};
            sym[2] = {1'b0, d1};
        end
        sym[3] = {1'b0, d0};

        for (int k = 0; k < 4; k++)
        begin
            g[k] = glyph(sym[k]);
        end
        for (int r = 0; r < 3; r++)
        begin
            com[r] = {g[3][3*r +: 3], g[2][3*r +: 3], g[1][3*r +: 3], g[0][3*r +: 3]};
        end
    end

    // The output register frees up whenever its result is taken.
    assign pop = !status.empty && (!valid_reg || !result_stall);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            oor_reg <= head_item.out_of_range;
            if (head_item.out_of_range)
            begin
                row0_low_reg  <= ERR_ROW0_LOW;
                row0_high_reg <= ERR_ROW0_HIGH;
                row1_low_reg  <= ERR_ROW1_LOW;
                row1_high_reg <= ERR_ROW1_HIGH;
                row2_low_reg  <= ERR_ROW2_LOW;
                row2_high_reg <= ERR_ROW2_HIGH;
            end
            else
            begin
                row0_low_reg  <= com[0][7:0];
                row0_high_reg <= com[0][11:8];
                row1_low_reg  <= {com[1][3:0], 4'b0};
                row1_high_reg <= com[1][11:4];
                row2_low_reg  <= com[2][7:0];
                row2_high_reg <= com[2][11:8];
            end
        end
    end

    assign result_valid = valid_reg;
    assign row0_low     = row0_low_reg;
    assign row0_high    = row0_high_reg;
    assign row1_low     = row1_low_reg;
    assign row1_high    = row1_high_reg;
    assign row2_low     = row2_low_reg;
    assign row2_high    = row2_high_reg;
    assign out_of_range = oor_reg;

endmodule

// File: rtl/core/signed_int_lcd_segment_encoder_top.sv
// Channel  | Handshake                    | Payload
// ---------+------------------------------+----------------------------------------
// value    | value_valid / value_stall    | value[15:0] signed
// result   | result_valid / result_stall  | row0..row2 low/high bytes, out_of_range
//
// One transaction per cycle is accepted and delivered in steady state while result_stall is low.
// From acceptance to result_valid, a transaction passes through the queue register
// and then the output register.
// value_stall rises only when the classified-item queue is full.
// Reset clears the queue pointers and count and the output valid flag; payload is not reset.
module signed_int_lcd_segment_encoder_top #(
    parameter int QUEUE_DEPTH = slcd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               value_valid,
    output logic               value_stall,
    input  logic signed [15:0] value,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [7:0]         row0_low,
    output logic [3:0]         row0_high,
    output logic [7:0]         row1_low,
    output logic [7:0]         row1_high,
    output logic [7:0]         row2_low,
    output logic [3:0]         row2_high,
    output logic               out_of_range
);
    import slcd_pkg::*;

    item_t         front_item;
    item_t         head_item;
    queue_status_t status;
    logic          push;
    logic          pop;

    assign value_stall = status.full;
    assign push        = value_valid && !status.full;

    slcd_front u_front (
        .value (value),
        .item  (front_item)
    );

    slcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (status)
    );

    slcd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_item    (head_item),
        .status       (status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .row0_low     (row0_low),
        .row0_high    (row0_high),
        .row1_low     (row1_low),
        .row1_high    (row1_high),
        .row2_low     (row2_low),
        .row2_high    (row2_high),
        .out_of_range (out_of_range)
    );

endmodule

// File: tb/signed_int_lcd_segment_encoder_top_test.sv
`timescale 1ns / 100ps

module signed_int_lcd_segment_encoder_top_test;

    import slcd_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 8;

    // Row patterns per symbol, written as octal {common 0, common 1, common 2}.
    // Symbols 0..9 and a..f, then minus, then blank.
    localparam logic [0:17][8:0] SEGMENT_ROWS = {
        9'o365, 9'o044, 9'o227, 9'o266, 9'o146, 9'o362, 9'o363, 9'o244, 9'o367,
        9'o366, 9'o347, 9'o163, 9'o321, 9'o067, 9'o323, 9'o303, 9'o002, 9'o000
    };

    typedef struct packed {
        logic signed [15:0] shown;
        logic [7:0]         row0_low;
        logic [3:0]         row0_high;
        logic [7:0]         row1_low;
        logic [7:0]         row1_high;
        logic [7:0]         row2_low;
        logic [3:0]         row2_high;
        logic               out_of_range;
    } lcd_image_t;

    typedef struct packed {
        logic signed [15:0] number;
        logic               drain_first;
    } display_request_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               value_valid = 1'b0;
    logic               value_stall;
    logic signed [15:0] value = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [7:0]         row0_low;
    logic [3:0]         row0_high;
    logic [7:0]         row1_low;
    logic [7:0]         row1_high;
    logic [7:0]         row2_low;
    logic [3:0]         row2_high;
    logic               out_of_range;

    display_request_t requests_pending[$];
    lcd_image_t       images_due[$];
    int               requests_total = 0;
    int               values_taken = 0;
    int               error_count = 0;
    int               cycle_count = 0;
    logic             value_taken = 1'b0;
    int               burst_left = 1;
    int               gap_left = 0;
    int               stall_run = 1;

    signed_int_lcd_segment_encoder_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .value_valid  (value_valid),
        .value_stall  (value_stall),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .row0_low     (row0_low),
        .row0_high    (row0_high),
        .row1_low     (row1_low),
        .row1_high    (row1_high),
        .row2_low     (row2_low),
        .row2_high    (row2_high),
        .out_of_range (out_of_range)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic lcd_image_t encode_display(input logic signed [15:0] v);
        lcd_image_t  img;
        int          n;
        int          mag;
        sym_t        slot [4];
        logic [11:0] com [3];
        img.shown = v;
        if (v < VALUE_MIN || v > VALUE_MAX)
        begin
            img.row0_low     = ERR_ROW0_LOW;
            img.row0_high    = ERR_ROW0_HIGH;
            img.row1_low     = ERR_ROW1_LOW;
            img.row1_high    = ERR_ROW1_HIGH;
            img.row2_low     = ERR_ROW2_LOW;
            img.row2_high    = ERR_ROW2_HIGH;
            img.out_of_range = 1'b1;
            return img;
        end
        n = v;
        mag = (n < 0) ? -n : n;
        if (n >= 0)
        begin
            slot[0] = (mag < 1000) ? SYM_BLANK : sym_t'((mag / 1000) % 10);
            slot[1] = (mag < 100) ? SYM_BLANK : sym_t'((mag / 100) % 10);
            slot[2] = (mag < 10) ? SYM_BLANK : sym_t'((mag / 10) % 10);
        end
        else if (mag < 10)
        begin
            slot[0] = SYM_BLANK;
            slot[1] = SYM_BLANK;
            slot[2] = SYM_MINUS;
        end
        else if (mag < 100)
        begin
            slot[0] = SYM_BLANK;
            slot[1] = SYM_MINUS;
            slot[2] = sym_t'((mag / 10) % 10);
        end
        else
        begin
            slot[0] = SYM_MINUS;
            slot[1] = sym_t'((mag / 100) % 10);
            slot[2] = sym_t'((mag / 10) % 10);
        end
        slot[3] = sym_t'(mag % 10);
        for (int r = 0; r < 3; r++)
        begin
            com[r] = '0;
            for (int k = 0; k < 4; k++)
                com[r] = com[r] | ({9'b0, SEGMENT_ROWS[slot[k]][8 - 3 * r -: 3]} << (3 * k));
        end
        img.row0_low     = com[0][7:0];
        img.row0_high    = com[0][11:8];
        img.row1_low     = {com[1][3:0], 4'b0};
        img.row1_high    = com[1][11:4];
        img.row2_low     = com[2][7:0];
        img.row2_high    = com[2][11:8];
        img.out_of_range = 1'b0;
        return img;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string field, input logic signed [15:0] shown,
                               input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("value %0d, %s is 0x%0h, expected 0x%0h",
                                      shown, field, got, want));
    endtask

    // Sender: bursts of transactions separated by random gaps.
    always @(negedge clk)
    begin : value_driver
        display_request_t req;
        if (!rst_n)
            value_valid <= 1'b0;
        else if (value_valid && !value_taken)
            ;
        else if (gap_left > 0)
        begin
            value_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (requests_pending.size() == 0 ||
                 (requests_pending[0].drain_first && images_due.size() != 0))
            value_valid <= 1'b0;
        else
        begin
            req = requests_pending.pop_front();
            value <= req.number;
            value_valid <= 1'b1;
            if (burst_left > 1)
                burst_left <= burst_left - 1;
            else
            begin
                burst_left <= ($urandom_range(5, 0) == 0) ? $urandom_range(80, 30)
                                                          : $urandom_range(12, 1);
                gap_left <= $urandom_range(6, 1);
            end
        end
    end

    // Receiver: alternating open and stalled runs, with an occasional long open run.
    always @(negedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (stall_run > 1)
            stall_run <= stall_run - 1;
        else if (result_stall)
        begin
            result_stall <= 1'b0;
            stall_run <= ($urandom_range(7, 0) == 0) ? $urandom_range(80, 40)
                                                     : $urandom_range(6, 1);
        end
        else
        begin
            result_stall <= 1'b1;
            stall_run <= $urandom_range(5, 1);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        lcd_image_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (images_due.size() == 0)
                    report_mismatch("result transaction with nothing expected");
                else
                begin
                    want = images_due.pop_front();
                    check_field("row0_low", want.shown, row0_low, want.row0_low);
                    check_field("row0_high", want.shown, row0_high, want.row0_high);
                    check_field("row1_low", want.shown, row1_low, want.row1_low);
                    check_field("row1_high", want.shown, row1_high, want.row1_high);
                    check_field("row2_low", want.shown, row2_low, want.row2_low);
                    check_field("row2_high", want.shown, row2_high, want.row2_high);
                    check_field("out_of_range", want.shown, out_of_range, want.out_of_range);
                end
            end
            if (value_valid && !value_stall)
            begin
                images_due.push_back(encode_display(value));
                values_taken++;
            end
        end
        value_taken <= rst_n && value_valid && !value_stall;
    end

    initial
    begin : stimulus
        int directed[$];
        int boundaries[$];
        int pick;
        int x;
        // Zero, digit-count boundaries on both sides, the range limits and the
        // full 16-bit extremes, plus a few mixed-digit values.
        directed = '{0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000, -1, -9,
                     -10, -99, -100, -999, -1000, 32767, -32768, 1234, 5678,
                     -505, 8090, 7, -42};
        boundaries = '{-1000, -999, -100, -99, -10, -9, 0, 9, 10, 99, 100, 999,
                       1000, 9999, 10000};
        foreach (directed[i])
            requests_pending.push_back('{16'(directed[i]), i == 12});
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 35)
                x = $urandom_range(9999, 0);
            else if (pick < 50)
                x = $urandom_range(99, 0);
            else if (pick < 65)
                x = -int'($urandom_range(999, 1));
            else if (pick < 80)
                x = boundaries[$urandom_range(14, 0)] + int'($urandom_range(2, 0)) - 1;
            else
                x = $urandom_range(65535, 0);
            requests_pending.push_back('{16'(x), (i % 97) == 50});
        end
        requests_total = requests_pending.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (values_taken < requests_total || images_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
